[rtl/hoc_pkg.sv]
`default_nettype none

package hoc_pkg;

	localparam int VertexW = 32;
	localparam int StabW   = 12;

	localparam int StateW = 2;
	localparam logic [StateW-1:0] ST_IDLE  = 2'd0;
	localparam logic [StateW-1:0] ST_PERM  = 2'd1;
	localparam logic [StateW-1:0] ST_SWEEP = 2'd2;

endpackage

`default_nettype wire

[rtl/hypercube_orbit_canonicalizer.sv]
// channel   | signals                                      | handshake
// ----------+----------------------------------------------+--------------------------------
// request   | vertex_set[31:0]                             | taken when start & !busy
// result    | orbit_representative[31:0],                  | valid for one cycle with done,
//           | complement_reachable, stabilizer_size[11:0]  | receiver cannot stall
//
// each request walks every coordinate permutation: per permutation the PERM state loads
// the permuted table, then in the SWEEP state the shared translate-and-compare unit
// checks one vertex offset per cycle.
// busy is high from the accept until the cycle of done; a new request can be taken
// in the done cycle. arst_n clears the sequencer and done; no clearing pass.
`default_nettype none

module hypercube_orbit_canonicalizer
	import hoc_pkg::*;
#(
	parameter int NUM_DIMS = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [VertexW-1:0] vertex_set,
	output logic                    done,
	output logic [VertexW-1:0]      orbit_representative,
	output logic                    complement_reachable,
	output logic [StabW-1:0]        stabilizer_size
);

	localparam int NV = 1 << NUM_DIMS;
	localparam int DW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int CW = $clog2(NUM_DIMS + 1);

	typedef logic [DW-1:0] digit_t;
	typedef digit_t [NUM_DIMS-1:0] digits_t;

	// lehmer code to coordinate permutation
	function automatic digits_t decode_perm(input digits_t code);
		digits_t p;
		logic [NUM_DIMS-1:0] used;
		logic [CW-1:0] cnt;
		p = '0;
		used = '0;
		for (int i = 0; i < NUM_DIMS; i++) begin
			cnt = '0;
			for (int j = 0; j < NUM_DIMS; j++) begin
				if (!used[j]) begin
					if (cnt == CW'(code[i])) begin
						p[i] = DW'(j);
					end
					cnt = cnt + 1'b1;
				end
			end
			used[p[i]] = 1'b1;
		end
		return p;
	endfunction

	// image bit at P(v) takes set bit v
	function automatic logic [NV-1:0] perm_table(input logic [NV-1:0] s, input digits_t p);
		logic [NV-1:0] t;
		logic [NUM_DIMS-1:0] v;
		logic [NUM_DIMS-1:0] wv;
		t = '0;
		for (int w = 0; w < NV; w++) begin
			wv = NUM_DIMS'(w);
			v = '0;
			for (int i = 0; i < NUM_DIMS; i++) begin
				v[p[i]] = wv[i];
			end
			t[w] = s[v];
		end
		return t;
	endfunction

	// translate by constant vertex c, one butterfly stage per coordinate
	function automatic logic [NV-1:0] translate(input logic [NV-1:0] x_in,
			input logic [NUM_DIMS-1:0] c);
		logic [NV-1:0] x;
		logic [NV-1:0] y;
		x = x_in;
		for (int j = 0; j < NUM_DIMS; j++) begin
			for (int u = 0; u < NV; u++) begin
				y[u] = c[j] ? x[u ^ (1 << j)] : x[u];
			end
			x = y;
		end
		return x;
	endfunction

	logic [StateW-1:0]   state_q;
	logic [NV-1:0]       set_q;
	logic [NV-1:0]       tab_q;
	logic [NUM_DIMS-1:0] c_q;
	digits_t             lehmer_q;
	logic [NV-1:0]       best_q;
	logic                swap_q;
	logic [StabW-1:0]    stab_q;
	logic                done_q;

	digits_t       lehmer_next;
	logic          lehmer_last;
	logic [NV-1:0] img;
	logic          accept;

	assign accept = start && !busy;

	always_comb begin
		logic carry;
		carry = 1'b1;
		lehmer_last = 1'b1;
		lehmer_next = lehmer_q;
		for (int i = 0; i < NUM_DIMS; i++) begin
			if (lehmer_q[i] != DW'(NUM_DIMS - 1 - i)) begin
				lehmer_last = 1'b0;
			end
			if (carry) begin
				if (lehmer_q[i] == DW'(NUM_DIMS - 1 - i)) begin
					lehmer_next[i] = '0;
				end else begin
					lehmer_next[i] = lehmer_q[i] + 1'b1;
					carry = 1'b0;
				end
			end
		end
	end

	assign img = translate(tab_q, c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PERM;
					end
				end
				ST_PERM: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (c_q == '1) begin
						if (lehmer_last) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_PERM;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					set_q    <= vertex_set[NV-1:0];
					lehmer_q <= '0;
					best_q   <= '1;
					swap_q   <= 1'b0;
					stab_q   <= '0;
				end
			end
			ST_PERM: begin
				tab_q <= perm_table(set_q, decode_perm(lehmer_q));
				c_q   <= '0;
			end
			ST_SWEEP: begin
				if (img < best_q) begin
					best_q <= img;
				end
				if (img == ~set_q) begin
					swap_q <= 1'b1;
				end
				if (img == set_q) begin
					stab_q <= stab_q + 1'b1;
				end
				c_q <= c_q + 1'b1;
				if (c_q == '1) begin
					lehmer_q <= lehmer_next;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy                 = (state_q != ST_IDLE);
	assign done                 = done_q;
	assign orbit_representative = VertexW'(best_q);
	assign complement_reachable = swap_q;
	assign stabilizer_size      = stab_q;

	a_done_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_SWEEP)
		else $error("done without a finished sweep");

	a_stab_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> stabilizer_size != '0)
		else $error("identity missing from stabilizer count");

	a_rep_not_above_set: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> best_q <= set_q)
		else $error("representative above the set itself");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && state_q == ST_PERM)
		else $error("request accepted but sequencer not started");

	a_perm_to_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PERM |=> state_q == ST_SWEEP && c_q == '0)
		else $error("offset sweep does not start at zero");

endmodule

`default_nettype wire

[tb/hoc_orbit_checker.sv]
`default_nettype none

module hoc_orbit_checker
	import hoc_pkg::*;
#(
	parameter int NUM_DIMS = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [VertexW-1:0] vertex_set,
	input  wire logic               done,
	input  wire logic [VertexW-1:0] orbit_representative,
	input  wire logic               complement_reachable,
	input  wire logic [StabW-1:0]   stabilizer_size,
	output int unsigned             outstanding,
	output int unsigned             mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VertexW-1:0] src;
		logic [VertexW-1:0] rep;
		logic               comp_flag;
		logic [StabW-1:0]   stab;
	} orbit_summary_t;

	orbit_summary_t pending_summaries[$];

	// sweep every coordinate permutation and every translation of the cube
	function automatic orbit_summary_t canonicalize(input logic [VertexW-1:0] raw);
		int unsigned nverts, total, idx, rem, i, c, v, y, stab;
		int unsigned digit [NUM_DIMS];
		logic [31:0] seen;
		logic [VertexW-1:0] full, members, comp, best, permuted, img;
		bit is_perm, swap;
		orbit_summary_t r;
		nverts = 1 << NUM_DIMS;
		full = '1;
		full = full >> (VertexW - nverts);
		members = raw & full;
		comp = full ^ members;
		best = '1;
		swap = 1'b0;
		stab = 0;
		total = 1;
		for (i = 0; i < NUM_DIMS; i++)
			total *= NUM_DIMS;
		for (idx = 0; idx < total; idx++) begin
			rem = idx;
			seen = '0;
			is_perm = 1'b1;
			for (i = 0; i < NUM_DIMS; i++) begin
				digit[i] = rem % NUM_DIMS;
				rem = rem / NUM_DIMS;
				if (seen[digit[i]])
					is_perm = 1'b0;
				seen[digit[i]] = 1'b1;
			end
			if (is_perm) begin
				permuted = '0;
				for (v = 0; v < nverts; v++) begin
					if (members[v]) begin
						y = 0;
						for (i = 0; i < NUM_DIMS; i++)
							y = y | (((v >> digit[i]) & 1) << i);
						permuted[y] = 1'b1;
					end
				end
				for (c = 0; c < nverts; c++) begin
					img = '0;
					for (v = 0; v < nverts; v++)
						img[v] = permuted[v ^ c];
					if (img < best)
						best = img;
					if (img == comp)
						swap = 1'b1;
					if (img == members)
						stab++;
				end
			end
		end
		r.src = raw;
		r.rep = best;
		r.comp_flag = swap;
		r.stab = StabW'(stab);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		orbit_summary_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_summaries.size() == 0) begin
					if (mismatches < 10)
						$display("%t: result with no request outstanding: rep %h", $realtime,
							orbit_representative);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_summaries.pop_front();
					if (orbit_representative !== want.rep
							|| complement_reachable !== want.comp_flag
							|| stabilizer_size !== want.stab) begin
						if (mismatches < 10)
							$display("%t: set %h: rep exp %h got %h, ", $realtime, want.src,
								want.rep, orbit_representative,
								"complement exp %b got %b, stabilizer exp %0d got %0d",
								want.comp_flag, complement_reachable,
								want.stab, stabilizer_size);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (start && !busy)
				pending_summaries.insert(pending_summaries.size(), canonicalize(vertex_set));
			outstanding <= pending_summaries.size();
		end
	end

endmodule

`default_nettype wire

[tb/tb_hypercube_orbit_canonicalizer.sv]
`default_nettype none

module tb_hypercube_orbit_canonicalizer;
	import hoc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit  = 20000;
	localparam int DrainCycles = 4000;
	localparam int PhaseItems  = 33;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VertexW-1:0] vertex_set;
	logic               done;
	logic [VertexW-1:0] orbit_representative;
	logic               complement_reachable;
	logic [StabW-1:0]   stabilizer_size;
	int unsigned        outstanding;
	int unsigned        mismatches;
	int unsigned        quiet_cycles = 0;

	logic [VertexW-1:0] directed_sets [0:17] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFE,
		32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000,
		32'h9669_6996, 32'h6996_9669, 32'h0001_0116, 32'hFEE9_E880, 32'h0000_000F,
		32'h8000_0001, 32'h1234_5678, 32'hA5C3_96F0
	};

	hypercube_orbit_canonicalizer DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.vertex_set           (vertex_set),
		.done                 (done),
		.orbit_representative (orbit_representative),
		.complement_reachable (complement_reachable),
		.stabilizer_size      (stabilizer_size)
	);

	hoc_orbit_checker orbit_check (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.vertex_set           (vertex_set),
		.done                 (done),
		.orbit_representative (orbit_representative),
		.complement_reachable (complement_reachable),
		.stabilizer_size      (stabilizer_size),
		.outstanding          (outstanding),
		.mismatches           (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QuietLimit) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// sparse, dense, symmetric and affine sets besides plain random words
	function automatic logic [VertexW-1:0] random_vertex_set();
		logic [VertexW-1:0] shaped;
		logic [5:0] weights;
		logic [4:0] mask, shift;
		int unsigned sel, v;
		shaped = '0;
		weights = 6'($urandom_range(63));
		mask = 5'($urandom_range(31));
		shift = 5'($urandom_range(31));
		sel = $urandom_range(4);
		case (sel)
			0: shaped = $urandom;
			1, 2: begin
				repeat ($urandom_range(1, 4))
					shaped[$urandom_range(31)] = 1'b1;
				if (sel == 2)
					shaped = ~shaped;
			end
			3: for (v = 0; v < 32; v++)
				shaped[v ^ shift] = weights[$countones(v)];
			default: for (v = 0; v < 32; v++)
				shaped[v] = (^(v[4:0] & mask)) ^ shift[0];
		endcase
		return shaped;
	endfunction

	task automatic issue_request(input logic [VertexW-1:0] value, input int unsigned idle_pct);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		start <= 1'b1;
		vertex_set <= value;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		int unsigned phase, n, idle_pct;
		arst_n = 1'b0;
		start = 1'b0;
		vertex_set = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_sets[k])
			issue_request(directed_sets[k], 0);
		wait_for_results();

		// idle phases: none, heavy, light, none
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 60 : (phase == 2) ? 15 : 0;
			for (n = 0; n < PhaseItems; n++)
				issue_request(random_vertex_set(), idle_pct);
			if (phase == 1)
				wait_for_results();
		end

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

[hypercube_orbit_canonicalizer.f]
rtl/hoc_pkg.sv
rtl/hypercube_orbit_canonicalizer.sv
tb/hoc_orbit_checker.sv
tb/tb_hypercube_orbit_canonicalizer.sv
